// ===== src/lz77_hash_chain_table_top_defines.svh =====
// Assertion helpers for the hash chain table.
`ifndef LZ77_HASH_CHAIN_TABLE_TOP_DEFINES_SVH
`define LZ77_HASH_CHAIN_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LZ77HC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define LZ77HC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/lz77hc_pkg.sv =====
`default_nettype none
package lz77hc_pkg;

   localparam int HASH_W         = 15;
   localparam int WINDOW_SIZE    = 32768;
   localparam int SHORTEST_MATCH = 3;
   localparam int POS_W          = 16;
   localparam int OP_W           = 2;
   localparam int HASH_OUT_W     = 15;
   localparam int WIN_W          = $clog2(WINDOW_SIZE);
   localparam int HASH_DEPTH     = 1 << HASH_W;
   localparam int HASH_SHIFT     = (HASH_W + SHORTEST_MATCH - 1) / SHORTEST_MATCH;
   // sweep covers the larger of the two tables
   localparam int SWEEP_W        = (HASH_W > WIN_W) ? HASH_W : WIN_W;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_FOLLOW = 2'd1,
      OP_SLIDE  = 2'd2
   } op_type;

   typedef struct packed {
      logic               st_clear;
      logic               st_idle;
      logic               st_exec;
      logic               sweep_wr;
      logic [SWEEP_W-1:0] idx;
      logic [SWEEP_W-1:0] sweep_addr;
   } ctl_type;

   // entry - WINDOW_SIZE, or 0 when the entry falls out of the window
   function automatic logic [POS_W-1:0] slide_entry(input logic [POS_W-1:0] v);
      logic [POS_W:0] d;
      d = {1'b0, v} - (POS_W+1)'(WINDOW_SIZE);
      return d[POS_W] ? '0 : d[POS_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== src/lz77_hash_chain_table_top.sv =====
// LZ77 hash chain table: a rolling hash plus a head table (indexed by hash) and a
// prev table (indexed by position mod window), both in single-port-read RAMs.
// Insert, follow and the unused op each go through a RAM read, then an exec state that
// loads the result register (an insert also writes back), held there while that
// register is full. A slide sweeps both tables through a read/write-back pipeline,
// one entry a cycle. After reset the block clears both tables with req_ready low.
// A finished word waits in the rsp register while the next word is accepted.
`default_nettype none
`include "lz77_hash_chain_table_top_defines.svh"
module lz77_hash_chain_table_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_op,
   input  wire logic [7:0]  req_byte_in,
   input  wire logic [15:0] req_position,
   input  wire logic [15:0] req_chain_pos,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_found_pos,
   output logic [14:0]      rsp_hash_now
);

   localparam int HW = lz77hc_pkg::HASH_W;
   localparam int WW = lz77hc_pkg::WIN_W;
   localparam int PW = lz77hc_pkg::POS_W;

   lz77hc_pkg::ctl_type ctl;

   logic          accept, out_free, done;
   logic [HW-1:0] hash_ff, hash_req;
   logic [1:0]    op_ff;
   logic [PW-1:0] pos_ff;
   logic [WW-1:0] chain_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_found_ff, found_in;
   logic [14:0]   rsp_hash_ff;

   logic          head_we, prev_we, head_in_range, prev_in_range;
   logic [HW-1:0] head_wa, head_ra;
   logic [WW-1:0] prev_wa, prev_ra;
   logic [PW-1:0] head_wd, prev_wd, head_rd, prev_rd;

   lz77hc_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .out_free  (out_free),
      .ctl       (ctl)
   );

   assign req_ready = ctl.st_idle;
   assign accept    = req_valid & req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign done      = ctl.st_exec & out_free;

   assign hash_req = HW'(hash_ff << lz77hc_pkg::HASH_SHIFT) ^ HW'(req_byte_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= '0;
      end else if (accept && req_op == lz77hc_pkg::OP_INSERT) begin
         hash_ff <= hash_req;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_op;
         pos_ff   <= req_position;
         chain_ff <= req_chain_pos[WW-1:0];
      end
   end

   // sweep runs over the larger table; skip indexes beyond the smaller one
   assign head_in_range = (int'(ctl.sweep_addr) < lz77hc_pkg::HASH_DEPTH);
   assign prev_in_range = (int'(ctl.sweep_addr) < lz77hc_pkg::WINDOW_SIZE);

   always_comb begin
      if (ctl.st_idle) begin
         head_ra = hash_req;
         prev_ra = req_chain_pos[WW-1:0];
      end else if (ctl.st_exec) begin
         head_ra = hash_ff;
         prev_ra = chain_ff;
      end else begin
         head_ra = HW'(ctl.idx);
         prev_ra = WW'(ctl.idx);
      end
   end

   always_comb begin
      head_we = ctl.st_clear || (ctl.sweep_wr && head_in_range) ||
                (done && op_ff == lz77hc_pkg::OP_INSERT);
      prev_we = ctl.st_clear || (ctl.sweep_wr && prev_in_range) ||
                (done && op_ff == lz77hc_pkg::OP_INSERT);
      if (ctl.st_clear) begin
         head_wa = HW'(ctl.idx);
         prev_wa = WW'(ctl.idx);
         head_wd = '0;
         prev_wd = '0;
      end else if (ctl.sweep_wr) begin
         head_wa = HW'(ctl.sweep_addr);
         prev_wa = WW'(ctl.sweep_addr);
         head_wd = lz77hc_pkg::slide_entry(head_rd);
         prev_wd = lz77hc_pkg::slide_entry(prev_rd);
      end else begin
         head_wa = hash_ff;
         prev_wa = pos_ff[WW-1:0];
         head_wd = pos_ff;
         prev_wd = head_rd;
      end
   end

   lz77hc_ram #(.WIDTH(PW), .DEPTH(lz77hc_pkg::HASH_DEPTH)) u_head_ram (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (head_wa),
      .wr_data (head_wd),
      .rd_addr (head_ra),
      .rd_data (head_rd)
   );

   lz77hc_ram #(.WIDTH(PW), .DEPTH(lz77hc_pkg::WINDOW_SIZE)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_wa),
      .wr_data (prev_wd),
      .rd_addr (prev_ra),
      .rd_data (prev_rd)
   );

   always_comb begin
      case (op_ff)
         lz77hc_pkg::OP_INSERT: found_in = 16'(head_rd);
         lz77hc_pkg::OP_FOLLOW: found_in = 16'(prev_rd);
         default:               found_in = '0;
      endcase
   end

   assign rsp_valid_in = done || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_found_ff <= found_in;
         rsp_hash_ff  <= 15'(hash_ff);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found_pos = rsp_found_ff;
   assign rsp_hash_now  = rsp_hash_ff;

   `LZ77HC_ASSERT_NOW(a_one_writer, clock, reset, 1'b1,
      $onehot0({ctl.st_clear, ctl.sweep_wr, done}),
      "more than one table write source active")
   `LZ77HC_ASSERT_NEXT(a_hash_hold, clock, reset,
      !(accept && req_op == lz77hc_pkg::OP_INSERT), $stable(hash_ff),
      "rolling hash changed without an insert")
   `LZ77HC_ASSERT_NEXT(a_slide_zero, clock, reset,
      done && op_ff == lz77hc_pkg::OP_SLIDE, rsp_valid && rsp_found_pos == 16'd0,
      "slide result must report no position")
   `LZ77HC_ASSERT_NOW(a_no_accept_busy, clock, reset, accept,
      !ctl.sweep_wr && !ctl.st_clear,
      "word accepted during a sweep")

endmodule
`default_nettype wire

// ===== src/lz77hc_ram.sv =====
`default_nettype none
module lz77hc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== src/lz77hc_seq.sv =====
`default_nettype none
module lz77hc_seq (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic [lz77hc_pkg::OP_W-1:0]   req_op,
   input  wire logic                          out_free,
   output lz77hc_pkg::ctl_type                ctl
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_EXEC  = 5'b00100,
      ST_SLIDE = 5'b01000,
      ST_FLUSH = 5'b10000
   } state_type;

   state_type                          state_ff, state_in;
   logic [lz77hc_pkg::SWEEP_W-1:0]     idx_ff, idx_in;
   logic [lz77hc_pkg::SWEEP_W-1:0]     sweep_addr_ff;
   logic                               sweep_wr_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_CLEAR: begin
            idx_in = lz77hc_pkg::SWEEP_W'(idx_ff + 1'b1);
            if (idx_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == lz77hc_pkg::OP_SLIDE) begin
                  state_in = ST_SLIDE;
                  idx_in   = '0;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SLIDE: begin
            idx_in = lz77hc_pkg::SWEEP_W'(idx_ff + 1'b1);
            if (idx_ff == '1) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            // last write-back of the sweep happens here
            state_in = ST_EXEC;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         idx_ff      <= '0;
         sweep_wr_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         sweep_wr_ff <= (state_ff == ST_SLIDE);
      end
   end

   // write-back address trails the read address by the RAM latency
   always_ff @(posedge clock) begin
      sweep_addr_ff <= idx_ff;
   end

   always_comb begin
      ctl.st_clear   = (state_ff == ST_CLEAR);
      ctl.st_idle    = (state_ff == ST_IDLE);
      ctl.st_exec    = (state_ff == ST_EXEC);
      ctl.sweep_wr   = sweep_wr_ff;
      ctl.idx        = idx_ff;
      ctl.sweep_addr = sweep_addr_ff;
   end

endmodule
`default_nettype wire

// ===== tb/sv/lz77_hash_chain_table_top_test.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lz77_hash_chain_table_top_test;
   import lz77hc_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   // slide sweep and post-reset clear each run with no handshake
   localparam int IDLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      logic [POS_W-1:0]      found_pos;
      logic [HASH_OUT_W-1:0] hash_now;
   } table_result_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [1:0]             req_op;
   logic [7:0]             req_byte_in;
   logic [15:0]            req_position;
   logic [15:0]            req_chain_pos;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [15:0]            rsp_found_pos;
   logic [14:0]            rsp_hash_now;

   // predicted table contents
   logic [HASH_W-1:0]      hash_reg;
   logic [POS_W-1:0]       head_mem [HASH_DEPTH];
   logic [POS_W-1:0]       prev_mem [WINDOW_SIZE];
   table_result_type       pending_results [$];

   int                     error_count = 0;
   int                     sent_count = 0;
   int                     idle_cycles = 0;
   bit                     burst_mode = 1'b0;

   lz77_hash_chain_table_top u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_byte_in   (req_byte_in),
      .req_position  (req_position),
      .req_chain_pos (req_chain_pos),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_found_pos (rsp_found_pos),
      .rsp_hash_now  (rsp_hash_now)
   );

   always #2 clock = ~clock;

   function automatic logic [POS_W-1:0] slide_down(input logic [POS_W-1:0] v);
      return (v >= POS_W'(WINDOW_SIZE)) ? v - POS_W'(WINDOW_SIZE) : '0;
   endfunction

   function automatic table_result_type table_step(input logic [1:0] op,
                                                   input logic [7:0] byte_val,
                                                   input logic [15:0] pos,
                                                   input logic [15:0] cpos);
      table_result_type r;
      r.found_pos = '0;
      case (op)
         OP_INSERT: begin
            hash_reg = (hash_reg << HASH_SHIFT) ^ HASH_W'(byte_val);
            r.found_pos = head_mem[hash_reg];
            prev_mem[pos[WIN_W-1:0]] = r.found_pos;
            head_mem[hash_reg] = pos;
         end
         OP_FOLLOW: r.found_pos = prev_mem[cpos[WIN_W-1:0]];
         OP_SLIDE: begin
            foreach (head_mem[i]) head_mem[i] = slide_down(head_mem[i]);
            foreach (prev_mem[i]) prev_mem[i] = slide_down(prev_mem[i]);
         end
         default: ;
      endcase
      r.hash_now = HASH_OUT_W'(hash_reg);
      return r;
   endfunction

   function automatic int draw_wait();
      return burst_mode ? 0 : $urandom_range(0, 19);
   endfunction

   task automatic report_error(input string msg);
      error_count++;
      $display("[%0t] ERROR: %s", $realtime, msg);
   endtask

   task automatic send_word(input logic [1:0] op, input logic [7:0] byte_val,
                            input logic [15:0] pos, input logic [15:0] cpos,
                            output logic [15:0] found);
      int               gap;
      table_result_type r;
      gap = draw_wait();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_op        <= op;
      req_byte_in   <= byte_val;
      req_position  <= pos;
      req_chain_pos <= cpos;
      do @(posedge clock); while (!req_ready);
      r = table_step(op, byte_val, pos, cpos);
      pending_results.push_back(r);
      found = r.found_pos;
      sent_count++;
   endtask

   // feed a run of bytes from a small alphabet so hashes repeat
   task automatic insert_run(input logic [15:0] base, input int n,
                             output logic [15:0] last_pos);
      logic [7:0]  alphabet [4];
      logic [7:0]  b;
      logic [15:0] found;
      int          letters;
      letters = $urandom_range(1, 4);
      foreach (alphabet[i]) alphabet[i] = 8'($urandom);
      last_pos = base;
      for (int i = 0; i < n; i++) begin
         b = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                         : alphabet[$urandom_range(0, letters - 1)];
         last_pos = base + 16'(i);
         send_word(OP_INSERT, b, last_pos, 16'($urandom), found);
      end
   endtask

   task automatic walk_chain(input logic [15:0] start, input int max_steps);
      logic [15:0] cpos;
      logic [15:0] found;
      cpos = start;
      for (int i = 0; i < max_steps; i++) begin
         send_word(OP_FOLLOW, 8'($urandom), 16'($urandom), cpos, found);
         if (found == '0) break;
         cpos = found;
      end
   endtask

   task automatic test_directed_edges();
      logic [15:0] found;
      send_word(OP_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF, found);
      send_word(OP_FOLLOW, 8'h00, 16'h0000, 16'h0000, found);
      send_word(OP_FOLLOW, 8'hFF, 16'hFFFF, 16'hFFFF, found);
      send_word(OP_INSERT, 8'h00, 16'h0000, 16'hFFFF, found);
      send_word(OP_INSERT, 8'hFF, 16'hFFFF, 16'h0000, found);
      send_word(OP_INSERT, 8'hFF, 16'h8000, 16'h0000, found);
      send_word(OP_INSERT, 8'hFF, 16'h7FFF, 16'h0000, found);
      // hash settles after three equal bytes, so this hits the last head
      send_word(OP_INSERT, 8'hFF, 16'h0001, 16'h0000, found);
      send_word(OP_FOLLOW, 8'h00, 16'h0000, 16'h0001, found);
      send_word(OP_FOLLOW, 8'h00, 16'h0000, 16'h7FFF, found);
      // chain positions beyond the window wrap
      send_word(OP_FOLLOW, 8'h00, 16'h0000, 16'hFFFF, found);
      send_word(OP_FOLLOW, 8'h00, 16'h0000, 16'h8000, found);
      send_word(OP_UNUSED, 8'hAA, 16'h5555, 16'hAAAA, found);
      send_word(OP_SLIDE, 8'h55, 16'hAAAA, 16'h5555, found);
      send_word(OP_FOLLOW, 8'h00, 16'h0000, 16'h0001, found);
      send_word(OP_INSERT, 8'hFF, 16'h1234, 16'h0000, found);
      send_word(OP_FOLLOW, 8'h00, 16'h0000, 16'h7FFF, found);
      for (int i = 0; i < 4; i++)
         send_word(OP_INSERT, 8'h00, 16'h8010 + 16'(i), 16'h0000, found);
      send_word(OP_FOLLOW, 8'h00, 16'h0000, 16'h8013, found);
      send_word(OP_FOLLOW, 8'h00, 16'h0000, 16'h0012, found);
   endtask

   task automatic test_chain_walks();
      logic [15:0] base;
      logic [15:0] last_pos;
      while (sent_count < 480) begin
         burst_mode = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 3))
            0: base = 16'(WINDOW_SIZE - 8 + $urandom_range(0, 16));
            1: base = 16'hFFF0 + 16'($urandom_range(0, 15));
            2: base = 16'($urandom_range(0, 64));
            default: base = 16'($urandom);
         endcase
         insert_run(base, $urandom_range(4, 16), last_pos);
         walk_chain(last_pos, $urandom_range(1, 8));
      end
   endtask

   task automatic test_slide_window();
      logic [15:0] base;
      logic [15:0] last_pos;
      logic [15:0] found;
      for (int round = 0; round < 3; round++) begin
         burst_mode = (round == 1);
         base = (round == 2) ? 16'hFFF0 : 16'(WINDOW_SIZE - 12 + $urandom_range(0, 24));
         insert_run(base, 24, last_pos);
         walk_chain(last_pos, 8);
         send_word(OP_SLIDE, 8'($urandom), 16'($urandom), 16'($urandom), found);
         walk_chain(last_pos, 8);
         walk_chain(base, 4);
         insert_run(16'($urandom), 10, last_pos);
         walk_chain(last_pos, 8);
      end
   endtask

   task automatic test_random_noise();
      logic [1:0]  op;
      logic [15:0] found;
      int          slides;
      slides = 0;
      while (sent_count < 750) begin
         if ((sent_count % 40) == 0)
            burst_mode = ($urandom_range(0, 3) == 0);
         op = 2'($urandom_range(0, 3));
         if (op == OP_SLIDE) begin
            if (slides < 2 && $urandom_range(0, 29) == 0)
               slides++;
            else
               op = OP_FOLLOW;
         end
         send_word(op, 8'($urandom), 16'($urandom), 16'($urandom), found);
      end
   endtask

   // result side: random stalls, then compare against the oldest prediction
   initial begin
      table_result_type want;
      int               stall;
      rsp_ready = 1'b0;
      wait (!reset);
      forever begin
         stall = draw_wait();
         repeat (stall) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pending_results.size() == 0) begin
            report_error($sformatf("word with nothing pending: found_pos %h hash_now %h",
                                   rsp_found_pos, rsp_hash_now));
         end else begin
            want = pending_results.pop_front();
            if (rsp_found_pos !== want.found_pos)
               report_error($sformatf("found_pos %h, expected %h",
                                      rsp_found_pos, want.found_pos));
            if (rsp_hash_now !== want.hash_now)
               report_error($sformatf("hash_now %h, expected %h",
                                      rsp_hash_now, want.hash_now));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("lz77_hash_chain_table_top verification failed");
         $finish;
      end
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_op        = OP_INSERT;
      req_byte_in   = '0;
      req_position  = '0;
      req_chain_pos = '0;
      hash_reg      = '0;
      foreach (head_mem[i]) head_mem[i] = '0;
      foreach (prev_mem[i]) prev_mem[i] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_edges();
      test_chain_walks();
      test_slide_window();
      test_random_noise();

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("lz77_hash_chain_table_top verification clean");
      else
         $display("lz77_hash_chain_table_top verification failed");
      $finish;
   end

endmodule
`default_nettype wire
